// ===== rtl/gdfw_pkg.sv =====
// Shared types, constants and helper functions for the depth-first walk block.
// Used by gdfw_ctrl, gdfw_datapath and graph_depth_first_walk; no dependencies.
`default_nettype none

package gdfw_pkg;

    localparam int MAX_VERTICES = 64;
    // rows and masks are 64 bits wide, so never more than 64 live vertices
    localparam int VLIM   = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int NV     = 64;
    localparam int VW     = 6;
    localparam int CW     = 7;

    typedef logic [NV-1:0] vmask_t;
    typedef logic [VW-1:0] vid_t;
    typedef logic [CW-1:0] vcnt_t;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_EDGE   = 2'd1,
        ACT_MEMBER = 2'd2,
        ACT_SEARCH = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDGE_WR,
        ST_POP,
        ST_ROW_RD,
        ST_CAND,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic latch_in;
        logic do_clear;
        logic do_member;
        logic edge_rd;
        logic edge_wr;
        logic search_start;
        logic search_err;
        logic pop;
        logic row_rd;
        logic load_cand;
        logic scan_emit;
        logic flush;
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        action_t action;
        logic    src_ok;
        logic    depth_zero;
        logic    cand_zero;
        logic    out_free;
    } status_t;

    // index of the lowest set bit; zero when none is set
    function automatic vid_t lowest_index(input vmask_t m);
        vid_t idx;
        idx = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    function automatic vmask_t range_mask(input vcnt_t n);
        vmask_t m;
        if (n[CW-1]) begin
            m = '1;
        end else begin
            m = (vmask_t'(1) << n[VW-1:0]) - vmask_t'(1);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/graph_depth_first_walk.sv =====
// Depth-first walk over a stored directed subgraph.
// Slave channel s_*: one word per item; s_tuser is the action (clear graph,
// write edge, write membership, search), s_tdata carries vertex_a, vertex_b
// and present. Master channel m_*: one word per discovered vertex of a
// search, with the source first and m_tlast on the final word. A source out
// of range or not a member gives one word with the error flag and m_tlast.
// cfg_we/cfg_wdata write vertex_count; write it only while the block is idle.
// Clear and membership writes pass through decode only; an edge write reads the row
// at decode and writes it back. A search steps through pop, row read, candidate load
// and scan for each popped vertex (a bad source goes straight to flush), a sequence
// set by the single read ports of the adjacency and stack memories; one discovery is
// issued per cycle from a priority-encoded scan of the candidate row while the output is free.
// Reset clears all edges (row valid bits), membership and the stack, and
// sets vertex_count to 64; no clearing pass is needed.
// A stalled receiver holds the output word; the walk waits for it, and a
// new item is taken only once the previous one's last word is in the output register.
// Depends on gdfw_pkg, gdfw_ctrl and gdfw_datapath.
`default_nettype none

module graph_depth_first_walk (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [5:0] vertex_a, [11:6] vertex_b, [12] present
    input  wire  [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // [5:0] vertex, [11:6] parent
    output logic [1:0]  m_tuser,   // [0] is_source, [1] error
    output logic        m_tlast,
    input  wire         cfg_we,
    input  wire  [6:0]  cfg_wdata  // vertex_count
);

    gdfw_pkg::cmd_t    cmd;
    gdfw_pkg::status_t status;

    gdfw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gdfw_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/gdfw_ctrl.sv =====
// Sequencer for the depth-first walk: decodes items and steps the walk.
// Depends on gdfw_pkg; drives the datapath through gdfw_pkg::cmd_t.
`default_nettype none

module gdfw_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  gdfw_pkg::status_t status,
    output gdfw_pkg::cmd_t    cmd
);

    gdfw_pkg::state_t state_reg;
    gdfw_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gdfw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gdfw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = gdfw_pkg::ST_DECODE;
                end
            end
            gdfw_pkg::ST_DECODE: begin
                unique case (status.action)
                    gdfw_pkg::ACT_EDGE:   state_next = gdfw_pkg::ST_EDGE_WR;
                    gdfw_pkg::ACT_SEARCH: begin
                        state_next = status.src_ok ? gdfw_pkg::ST_POP : gdfw_pkg::ST_FLUSH;
                    end
                    default:              state_next = gdfw_pkg::ST_IDLE;
                endcase
            end
            gdfw_pkg::ST_EDGE_WR: state_next = gdfw_pkg::ST_IDLE;
            gdfw_pkg::ST_POP: begin
                state_next = status.depth_zero ? gdfw_pkg::ST_FLUSH : gdfw_pkg::ST_ROW_RD;
            end
            gdfw_pkg::ST_ROW_RD: state_next = gdfw_pkg::ST_CAND;
            gdfw_pkg::ST_CAND:   state_next = gdfw_pkg::ST_SCAN;
            gdfw_pkg::ST_SCAN: begin
                if (status.cand_zero) begin
                    state_next = gdfw_pkg::ST_POP;
                end
            end
            gdfw_pkg::ST_FLUSH: begin
                if (status.out_free) begin
                    state_next = gdfw_pkg::ST_IDLE;
                end
            end
            default: state_next = gdfw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            gdfw_pkg::ST_IDLE: begin
                s_tready     = 1'b1;
                cmd.latch_in = s_tvalid;
            end
            gdfw_pkg::ST_DECODE: begin
                unique case (status.action)
                    gdfw_pkg::ACT_CLEAR:  cmd.do_clear  = 1'b1;
                    gdfw_pkg::ACT_EDGE:   cmd.edge_rd   = 1'b1;
                    gdfw_pkg::ACT_MEMBER: cmd.do_member = 1'b1;
                    default: begin
                        cmd.search_start = status.src_ok;
                        cmd.search_err   = !status.src_ok;
                    end
                endcase
            end
            gdfw_pkg::ST_EDGE_WR: cmd.edge_wr   = 1'b1;
            gdfw_pkg::ST_POP:     cmd.pop       = !status.depth_zero;
            gdfw_pkg::ST_ROW_RD:  cmd.row_rd    = 1'b1;
            gdfw_pkg::ST_CAND:    cmd.load_cand = 1'b1;
            gdfw_pkg::ST_SCAN:    cmd.scan_emit = !status.cand_zero && status.out_free;
            gdfw_pkg::ST_FLUSH:   cmd.flush     = status.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gdfw_datapath.sv =====
// Datapath of the depth-first walk: adjacency memory, stack memory, masks,
// candidate scan and result buffering. Depends on gdfw_pkg.
`default_nettype none

module gdfw_datapath (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  gdfw_pkg::cmd_t        cmd,
    output gdfw_pkg::status_t     status,
    input  wire  [15:0]           s_tdata,
    input  wire  [1:0]            s_tuser,
    input  wire                   cfg_we,
    input  wire  [6:0]            cfg_wdata,
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [15:0]           m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    // memories
    gdfw_pkg::vmask_t adj_mem [gdfw_pkg::NV];
    gdfw_pkg::vid_t   stk_mem [gdfw_pkg::NV];

    // item and configuration
    gdfw_pkg::action_t act_reg;
    gdfw_pkg::vid_t    a_reg;
    gdfw_pkg::vid_t    b_reg;
    logic              pres_reg;
    gdfw_pkg::vcnt_t   vcount_reg;

    // graph and walk state
    gdfw_pkg::vmask_t rowv_reg, rowv_next;
    gdfw_pkg::vmask_t member_reg, member_next;
    gdfw_pkg::vmask_t allowed_reg;
    gdfw_pkg::vmask_t seen_reg, seen_next;
    gdfw_pkg::vmask_t cand_reg, cand_next;
    gdfw_pkg::vcnt_t  depth_reg, depth_next;
    gdfw_pkg::vid_t   cur_reg;
    gdfw_pkg::vmask_t row_rd_reg;
    logic             row_ok_reg;
    gdfw_pkg::vid_t   stk_rd_reg;

    // held result and output word
    logic             hv_reg, hv_next;
    gdfw_pkg::vid_t   h_vertex_reg, h_parent_reg;
    logic             h_src_reg, h_err_reg;
    logic             mv_reg, mv_next;
    gdfw_pkg::vid_t   o_vertex_reg, o_parent_reg;
    logic             o_src_reg, o_err_reg, o_last_reg;

    gdfw_pkg::vcnt_t  act_count;
    gdfw_pkg::vmask_t allowed;
    gdfw_pkg::vmask_t row_base;
    gdfw_pkg::vmask_t row_new;
    gdfw_pkg::vid_t   adj_addr;
    gdfw_pkg::vid_t   nb;
    gdfw_pkg::vcnt_t  depth_dec;
    logic             src_ok;
    logic             edge_in_range;
    logic             out_free;

    assign act_count = (vcount_reg > gdfw_pkg::vcnt_t'(gdfw_pkg::VLIM)) ?
                       gdfw_pkg::vcnt_t'(gdfw_pkg::VLIM) : vcount_reg;
    assign allowed   = member_reg & gdfw_pkg::range_mask(act_count);
    assign src_ok    = ({1'b0, a_reg} < act_count) && allowed[a_reg];
    assign edge_in_range = ({1'b0, a_reg} < gdfw_pkg::vcnt_t'(gdfw_pkg::VLIM)) &&
                           ({1'b0, b_reg} < gdfw_pkg::vcnt_t'(gdfw_pkg::VLIM));
    assign row_base  = row_ok_reg ? row_rd_reg : '0;
    assign adj_addr  = cmd.edge_rd ? a_reg : stk_rd_reg;
    assign nb        = gdfw_pkg::lowest_index(cand_reg);
    assign depth_dec = depth_reg - gdfw_pkg::vcnt_t'(1);
    assign out_free  = !mv_reg || m_tready;

    always_comb begin
        row_new = row_base;
        row_new[b_reg] = pres_reg;
    end

    assign status.action     = act_reg;
    assign status.src_ok     = src_ok;
    assign status.depth_zero = (depth_reg == '0);
    assign status.cand_zero  = (cand_reg == '0);
    assign status.out_free   = out_free;

    // item latch and configuration register
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            act_reg  <= gdfw_pkg::action_t'(s_tuser);
            a_reg    <= s_tdata[5:0];
            b_reg    <= s_tdata[11:6];
            pres_reg <= s_tdata[12];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= gdfw_pkg::vcnt_t'(64);
        end else if (cfg_we) begin
            vcount_reg <= cfg_wdata;
        end
    end

    // adjacency rows: one read port, one write port; row valid bits stand for clear
    always_ff @(posedge aclk) begin
        if (cmd.edge_wr && edge_in_range) begin
            adj_mem[a_reg] <= row_new;
        end
        if (cmd.edge_rd || cmd.row_rd) begin
            row_rd_reg <= adj_mem[adj_addr];
            row_ok_reg <= rowv_reg[adj_addr];
        end
    end

    // stack
    always_ff @(posedge aclk) begin
        if (cmd.search_start) begin
            stk_mem[0] <= a_reg;
        end else if (cmd.scan_emit && !depth_reg[gdfw_pkg::CW-1]) begin
            stk_mem[depth_reg[gdfw_pkg::VW-1:0]] <= nb;
        end
        if (cmd.pop) begin
            stk_rd_reg <= stk_mem[depth_dec[gdfw_pkg::VW-1:0]];
        end
    end

    always_comb begin
        rowv_next   = rowv_reg;
        member_next = member_reg;
        seen_next   = seen_reg;
        cand_next   = cand_reg;
        depth_next  = depth_reg;
        hv_next     = hv_reg;
        mv_next     = mv_reg && !m_tready;
        if (cmd.do_clear) begin
            rowv_next   = '0;
            member_next = '0;
        end
        if (cmd.do_member && ({1'b0, a_reg} < gdfw_pkg::vcnt_t'(gdfw_pkg::VLIM))) begin
            member_next[a_reg] = pres_reg;
        end
        if (cmd.edge_wr && edge_in_range) begin
            rowv_next[a_reg] = 1'b1;
        end
        if (cmd.search_start) begin
            seen_next        = '0;
            seen_next[a_reg] = 1'b1;
            depth_next       = gdfw_pkg::vcnt_t'(1);
            hv_next          = 1'b1;
        end
        if (cmd.search_err) begin
            hv_next = 1'b1;
        end
        if (cmd.pop) begin
            depth_next = depth_dec;
        end
        if (cmd.load_cand) begin
            cand_next = row_base & allowed_reg & ~seen_reg;
        end
        if (cmd.scan_emit) begin
            // clear lowest set bit, mark it seen, push it
            cand_next = cand_reg & (cand_reg - gdfw_pkg::vmask_t'(1));
            seen_next = seen_reg | (cand_reg & ~cand_next);
            if (!depth_reg[gdfw_pkg::CW-1]) begin
                depth_next = depth_reg + gdfw_pkg::vcnt_t'(1);
            end
            mv_next = 1'b1;
        end
        if (cmd.flush) begin
            hv_next = 1'b0;
            mv_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rowv_reg   <= '0;
            member_reg <= '0;
            seen_reg   <= '0;
            depth_reg  <= '0;
            hv_reg     <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            rowv_reg   <= rowv_next;
            member_reg <= member_next;
            seen_reg   <= seen_next;
            depth_reg  <= depth_next;
            hv_reg     <= hv_next;
            mv_reg     <= mv_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cand_reg <= cand_next;
        if (cmd.search_start) begin
            allowed_reg <= allowed;
        end
        if (cmd.row_rd) begin
            cur_reg <= stk_rd_reg;
        end
        if (cmd.search_start || cmd.search_err) begin
            h_vertex_reg <= a_reg;
            h_parent_reg <= a_reg;
            h_src_reg    <= cmd.search_start;
            h_err_reg    <= cmd.search_err;
        end else if (cmd.scan_emit) begin
            h_vertex_reg <= nb;
            h_parent_reg <= cur_reg;
            h_src_reg    <= 1'b0;
            h_err_reg    <= 1'b0;
        end
        // the held word goes out once its successor is known, or at the end
        if (cmd.scan_emit || cmd.flush) begin
            o_vertex_reg <= h_vertex_reg;
            o_parent_reg <= h_parent_reg;
            o_src_reg    <= h_src_reg;
            o_err_reg    <= h_err_reg;
            o_last_reg   <= cmd.flush;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'b0000, o_parent_reg, o_vertex_reg};
    assign m_tuser  = {o_err_reg, o_src_reg};
    assign m_tlast  = o_last_reg;

endmodule

`default_nettype wire
